@@ rtl/kpd_pkg.sv @@
`default_nettype none
package kpd_pkg;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [1:0] REG_START_MARK = 2'd0;
  localparam logic [1:0] REG_TERMINATOR = 2'd1;
  localparam logic [1:0] REG_MIN_LENGTH = 2'd2;

  localparam logic [7:0] RESET_START_MARK = 8'd1;
  localparam logic [7:0] RESET_TERMINATOR = 8'd13;
  localparam logic [6:0] RESET_MIN_LENGTH = 7'd3;

  localparam logic [6:0] LEN_FLOOR   = 7'd3;
  localparam logic [8:0] LEN_OFFSET  = 9'd32;
  localparam logic [8:0] LEN_CEILING = 9'd127;
  localparam logic [7:0] CHAR_OFFSET = 8'd32;

  localparam logic RESULT_PAYLOAD = 1'b0;
  localparam logic RESULT_STATUS  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT_LEN = 2'd1;
  localparam logic [1:0] STATUS_BAD_TERM  = 2'd2;
  localparam logic [1:0] STATUS_BAD_CHECK = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_SEQ   = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_TERM  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] start_mark;
    logic [7:0] terminator;
    logic [6:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] seq_number;
    logic [7:0] packet_type;
    logic [1:0] status;
    logic [6:0] payload_count;
  } result_t;

  function automatic logic [5:0] fold_check(input logic [7:0] s);
    logic [5:0] f;
    f = s[5:0] + {4'd0, s[7:6]};
    return f;
  endfunction

endpackage
`default_nettype wire

@@ rtl/kermit_packet_deframer_core.sv @@
// channel  | direction | handshake             | payload
// rx       | in        | in_valid / in_ready   | rx_byte
// result   | out       | out_valid / out_ready | result_kind .. payload_count
// config   | in        | apb (pready tied high)| paddr, pwdata, prdata
//
// one byte per cycle sustained while the output queue has space; each byte is
// registered in the input register, then the framing state machine updates and
// writes its result, if any, into a two-entry output queue, from which the result
// is offered on out_valid / out_ready.
// in_ready drops only while the output queue is full and the input register holds.
// synchronous reset clears framing state, the input register and the output queue,
// config goes to defaults.
`default_nettype none
module kermit_packet_deframer_core
  import kpd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              rx_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         result_kind,
  output logic      [7:0]              payload_byte,
  output logic      [7:0]              seq_number,
  output logic      [7:0]              packet_type,
  output logic      [1:0]              status,
  output logic      [6:0]              payload_count,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CfgAddrWidth-1:0] paddr,
  input  wire logic [CfgDataWidth-1:0] pwdata,
  output logic      [CfgDataWidth-1:0] prdata,
  output logic                         pready
);

  cfg_t       cfg;
  logic       in_full;
  logic [7:0] in_byte;
  logic       has_space;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign pready   = 1'b1;
  assign advance  = in_full && has_space;
  assign in_ready = !in_full || has_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= rx_byte;
  end

  kpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  kpd_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_in   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  kpd_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_data (res),
    .has_space (has_space),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_data)
  );

  assign result_kind   = out_data.result_kind;
  assign payload_byte  = out_data.payload_byte;
  assign seq_number    = out_data.seq_number;
  assign packet_type   = out_data.packet_type;
  assign status        = out_data.status;
  assign payload_count = out_data.payload_count;

endmodule
`default_nettype wire

@@ rtl/kpd_cfg_regs.sv @@
`default_nettype none
module kpd_cfg_regs
  import kpd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CfgAddrWidth-1:0] paddr,
  input  wire logic [CfgDataWidth-1:0] pwdata,
  output logic      [CfgDataWidth-1:0] prdata,
  output cfg_t                         cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_mark <= RESET_START_MARK;
      cfg.terminator <= RESET_TERMINATOR;
      cfg.min_length <= RESET_MIN_LENGTH;
    end else if (wr_en) begin
      case (reg_index)
        REG_START_MARK: cfg.start_mark <= pwdata[7:0];
        REG_TERMINATOR: cfg.terminator <= pwdata[7:0];
        REG_MIN_LENGTH: cfg.min_length <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_START_MARK: prdata = {24'd0, cfg.start_mark};
      REG_TERMINATOR: prdata = {24'd0, cfg.terminator};
      REG_MIN_LENGTH: prdata = {25'd0, cfg.min_length};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/kpd_frame_fsm.sv @@
`default_nettype none
module kpd_frame_fsm
  import kpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] byte_in,
  input  cfg_t            cfg,
  output logic            res_valid,
  output result_t         res
);

  phase_t     phase, phase_next;
  logic [6:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_seq, held_seq_next;
  logic [7:0] held_type, held_type_next;
  logic [7:0] held_check, held_check_next;
  logic [6:0] payload_seen, payload_seen_next;

  logic [6:0] len_lo;
  logic       len_bad;
  logic [7:0] check_expect;

  assign len_lo       = (cfg.min_length < LEN_FLOOR) ? LEN_FLOOR : cfg.min_length;
  assign len_bad      = ({1'b0, byte_in} < (LEN_OFFSET + {2'd0, len_lo}))
                        || ({1'b0, byte_in} > LEN_CEILING);
  assign check_expect = {2'd0, fold_check(running_sum)} + CHAR_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      bytes_left   <= '0;
      running_sum  <= '0;
      held_seq     <= '0;
      held_type    <= '0;
      held_check   <= '0;
      payload_seen <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      running_sum  <= running_sum_next;
      held_seq     <= held_seq_next;
      held_type    <= held_type_next;
      held_check   <= held_check_next;
      payload_seen <= payload_seen_next;
    end
  end

  // next state
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    held_seq_next     = held_seq;
    held_type_next    = held_type;
    held_check_next   = held_check;
    payload_seen_next = payload_seen;
    case (phase)
      PH_HUNT: begin
        if (byte_in == cfg.start_mark) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (len_bad) begin
          phase_next = PH_HUNT;
        end else begin
          running_sum_next  = byte_in;
          bytes_left_next   = byte_in[6:0] - 7'd35;
          payload_seen_next = '0;
          phase_next        = PH_SEQ;
        end
      end
      PH_SEQ: begin
        held_seq_next    = byte_in - CHAR_OFFSET;
        running_sum_next = running_sum + byte_in;
        phase_next       = PH_TYPE;
      end
      PH_TYPE: begin
        held_type_next   = byte_in;
        running_sum_next = running_sum + byte_in;
        phase_next       = (bytes_left == '0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        running_sum_next  = running_sum + byte_in;
        payload_seen_next = payload_seen + 7'd1;
        bytes_left_next   = bytes_left - 7'd1;
        if (bytes_left == 7'd1) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        held_check_next = byte_in;
        phase_next      = PH_TERM;
      end
      PH_TERM: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      PH_LEN: begin
        if (len_bad) begin
          res_valid       = 1'b1;
          res.result_kind = RESULT_STATUS;
          res.status      = STATUS_SHORT_LEN;
        end
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.result_kind  = RESULT_PAYLOAD;
        res.payload_byte = byte_in;
        res.seq_number   = held_seq;
        res.packet_type  = held_type;
      end
      PH_TERM: begin
        res_valid         = 1'b1;
        res.result_kind   = RESULT_STATUS;
        res.seq_number    = held_seq;
        res.packet_type   = held_type;
        res.payload_count = payload_seen;
        if (byte_in != cfg.terminator) begin
          res.status = STATUS_BAD_TERM;
        end else if (held_check != check_expect) begin
          res.status = STATUS_BAD_CHECK;
        end else begin
          res.status = STATUS_OK;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/kpd_out_fifo.sv @@
`default_nettype none
module kpd_out_fifo
  import kpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  result_t   push_data,
  output logic      has_space,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output result_t   pop_data
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != 2'd0);
  assign has_space = (count != 2'd2);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/kpd_checker.sv @@
`default_nettype none
module kpd_checker
  import kpd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       result_kind,
  input wire logic [1:0] status,
  input wire logic [7:0] seq_number,
  input wire logic [7:0] packet_type,
  input wire logic [6:0] payload_count,
  input wire logic       pready
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transfer dropped while stalled");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_PAYLOAD |-> status == STATUS_OK
      && payload_count == 7'd0)
    else $error("payload result carries status fields");

  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_STATUS && status == STATUS_SHORT_LEN
      |-> seq_number == 8'd0 && packet_type == 8'd0 && payload_count == 7'd0)
    else $error("short length status carries packet fields");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind kermit_packet_deframer_core kpd_checker u_kpd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_kind   (result_kind),
  .status        (status),
  .seq_number    (seq_number),
  .packet_type   (packet_type),
  .payload_count (payload_count),
  .pready        (pready)
);
`default_nettype wire
